FILE: rtl/mcfe_pkg.sv
// Shared constants and types for the MIT-mode command frame encoder.
// No dependencies; every other RTL file except mcfe_check refers to this package by scoped names.
package mcfe_pkg;

  localparam int NUM_CH = 5;   // position, velocity, stiffness, damping, torque
  localparam int IN_W   = 32;  // Q16.16 input value
  localparam int OFF_W  = 25;  // saturated value minus lower limit, largest span is 500.0
  localparam int TOP_W  = 16;
  localparam int N_W    = 21;  // scaled offset after the power-of-two part of the span
  localparam int M_W    = 20;  // reciprocal width
  localparam int D_W    = 7;   // odd part of the span
  localparam int Q_W    = 16;  // code width, widest lane
  localparam int RECIP_S = 22; // reciprocal scale 2^22, above the largest dividend
  localparam int FRAME_W = 64;

  typedef logic [OFF_W-1:0] off_t;
  typedef logic [N_W-1:0]   num_t;
  typedef logic [Q_W-1:0]   code_t;

  // span = 2^SHIFT * DIV for every lane
  localparam logic signed [IN_W-1:0] LO [NUM_CH] =
    '{-32'sd819200, -32'sd4259840, 32'sd0, 32'sd0, -32'sd1179648};
  localparam logic signed [IN_W-1:0] HI [NUM_CH] =
    '{32'sd819200, 32'sd4259840, 32'sd32768000, 32'sd327680, 32'sd1179648};
  localparam logic [TOP_W-1:0] TOP [NUM_CH] =
    '{16'hFFFF, 16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF};
  localparam int SHIFT [NUM_CH] = '{16, 17, 18, 16, 18};
  localparam logic [D_W-1:0] DIV [NUM_CH] = '{7'd25, 7'd65, 7'd125, 7'd5, 7'd9};
  // floor(2^22 / DIV)
  localparam logic [M_W-1:0] RECIP [NUM_CH] =
    '{20'd167772, 20'd64527, 20'd33554, 20'd838860, 20'd466033};

endpackage

FILE: rtl/mcfe_clamp.sv
// Stage 1: saturates each Q16.16 value to its limits and takes the offset
// from the lower limit. Uses mcfe_pkg.
module mcfe_clamp (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic [mcfe_pkg::NUM_CH*mcfe_pkg::IN_W-1:0]   in_data,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output mcfe_pkg::off_t [mcfe_pkg::NUM_CH-1:0]        off
);

  mcfe_pkg::off_t [mcfe_pkg::NUM_CH-1:0] off_next;

  for (genvar i = 0; i < mcfe_pkg::NUM_CH; i++) begin : g_lane
    logic signed [mcfe_pkg::IN_W-1:0] x;
    logic signed [mcfe_pkg::IN_W-1:0] c;
    logic signed [mcfe_pkg::IN_W:0]   diff;
    always_comb begin
      x = signed'(in_data[i*mcfe_pkg::IN_W +: mcfe_pkg::IN_W]);
      if (x < mcfe_pkg::LO[i]) begin
        c = mcfe_pkg::LO[i];
      end else if (x > mcfe_pkg::HI[i]) begin
        c = mcfe_pkg::HI[i];
      end else begin
        c = x;
      end
      diff = {c[mcfe_pkg::IN_W-1], c} -
             {mcfe_pkg::LO[i][mcfe_pkg::IN_W-1], mcfe_pkg::LO[i]};
      off_next[i] = diff[mcfe_pkg::OFF_W-1:0];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      off <= off_next;
    end
  end

endmodule

FILE: rtl/mcfe_scale.sv
// Stage 2: multiplies each offset by the code's full scale and drops the
// power-of-two part of the span. Uses mcfe_pkg.
module mcfe_scale (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  mcfe_pkg::off_t [mcfe_pkg::NUM_CH-1:0] off,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output mcfe_pkg::num_t [mcfe_pkg::NUM_CH-1:0] num
);

  localparam int P_W = mcfe_pkg::OFF_W + mcfe_pkg::TOP_W;

  mcfe_pkg::num_t [mcfe_pkg::NUM_CH-1:0] num_next;

  for (genvar i = 0; i < mcfe_pkg::NUM_CH; i++) begin : g_lane
    logic [P_W-1:0] prod;
    logic [P_W-1:0] sh;
    always_comb begin
      prod = P_W'(off[i]) * P_W'(mcfe_pkg::TOP[i]);
      sh   = prod >> mcfe_pkg::SHIFT[i];
      num_next[i] = sh[mcfe_pkg::N_W-1:0];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      num <= num_next;
    end
  end

endmodule

FILE: rtl/mcfe_recip.sv
// Stage 3: estimates num / DIV by a reciprocal multiply; the estimate is
// exact or one low. Uses mcfe_pkg.
module mcfe_recip (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  mcfe_pkg::num_t  [mcfe_pkg::NUM_CH-1:0] num,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output mcfe_pkg::num_t  [mcfe_pkg::NUM_CH-1:0] num_q,
  output mcfe_pkg::code_t [mcfe_pkg::NUM_CH-1:0] est
);

  localparam int R_W = mcfe_pkg::N_W + mcfe_pkg::M_W;

  mcfe_pkg::code_t [mcfe_pkg::NUM_CH-1:0] est_next;

  for (genvar i = 0; i < mcfe_pkg::NUM_CH; i++) begin : g_lane
    logic [R_W-1:0] prod;
    always_comb begin
      prod = R_W'(num[i]) * R_W'(mcfe_pkg::RECIP[i]);
      est_next[i] = prod[mcfe_pkg::RECIP_S +: mcfe_pkg::Q_W];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      num_q <= num;
      est   <= est_next;
    end
  end

endmodule

FILE: rtl/mcfe_fix.sv
// Stage 4: corrects the quotient estimate by the remainder and packs the
// codes big-endian into the frame. Output register of the pipe. Uses mcfe_pkg.
module mcfe_fix (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  mcfe_pkg::num_t  [mcfe_pkg::NUM_CH-1:0] num,
  input  mcfe_pkg::code_t [mcfe_pkg::NUM_CH-1:0] est,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [mcfe_pkg::FRAME_W-1:0]           frame
);

  localparam int QD_W = mcfe_pkg::Q_W + mcfe_pkg::D_W;

  mcfe_pkg::code_t [mcfe_pkg::NUM_CH-1:0] code;
  logic [mcfe_pkg::FRAME_W-1:0]           frame_next;

  for (genvar i = 0; i < mcfe_pkg::NUM_CH; i++) begin : g_lane
    logic [QD_W-1:0] qd;
    logic [QD_W-1:0] rem;
    always_comb begin
      qd  = QD_W'(est[i]) * QD_W'(mcfe_pkg::DIV[i]);
      rem = QD_W'(num[i]) - qd;
      if (rem >= QD_W'(mcfe_pkg::DIV[i])) begin
        code[i] = est[i] + mcfe_pkg::Q_W'(1);
      end else begin
        code[i] = est[i];
      end
    end
  end

  // position takes 16 bits, the rest 12 each
  assign frame_next = {code[0], code[1][11:0], code[2][11:0], code[3][11:0], code[4][11:0]};

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      frame <= frame_next;
    end
  end

endmodule

FILE: rtl/mit_command_frame_encoder.sv
// Top level of the MIT-mode command frame encoder: four pipeline stages.
// Depends on mcfe_pkg, mcfe_clamp, mcfe_scale, mcfe_recip and mcfe_fix.
//
// One command beat in, one frame beat out. Each of the five Q16.16 values is
// saturated to its limit, then mapped to floor((c-min)*(2^bits-1)/(max-min))
// and the codes are packed big-endian, position code in bits 63..48. The pipe
// has four register stages (clamp, full-scale multiply, reciprocal multiply,
// remainder correction), and each command beat passes through them in that order.
// A new command is taken every cycle while the output is not stalled.
// A stalled output holds its frame; the stages ahead keep filling any bubbles
// and take new beats until all four stages are full.
module mit_command_frame_encoder (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // position, velocity, stiffness, damping, torque: 32 bits each from bit 0
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // frame
  output logic [63:0]  m_axis_tdata
);

  logic v1, r1, v2, r2, v3, r3;

  mcfe_pkg::off_t  [mcfe_pkg::NUM_CH-1:0] off;
  mcfe_pkg::num_t  [mcfe_pkg::NUM_CH-1:0] num;
  mcfe_pkg::num_t  [mcfe_pkg::NUM_CH-1:0] num_q;
  mcfe_pkg::code_t [mcfe_pkg::NUM_CH-1:0] est;

  mcfe_clamp u_clamp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .out_valid (v1),
    .out_ready (r1),
    .off       (off)
  );

  mcfe_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ready  (r1),
    .off       (off),
    .out_valid (v2),
    .out_ready (r2),
    .num       (num)
  );

  mcfe_recip u_recip (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (r2),
    .num       (num),
    .out_valid (v3),
    .out_ready (r3),
    .num_q     (num_q),
    .est       (est)
  );

  mcfe_fix u_fix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_ready  (r3),
    .num       (num_q),
    .est       (est),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .frame     (m_axis_tdata)
  );

endmodule

FILE: rtl/mcfe_check.sv
// Port-level checks for the MIT-mode command frame encoder, bound to the top.
// Depends on mit_command_frame_encoder only through its ports.
module mcfe_check (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [63:0]  m_axis_tdata
);

  // pipe is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // a free-flowing output never back-pressures the input
  a_flow_ready: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output ready");

  // a beat reaches the output when nothing stalls it
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
      ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("frame missing four cycles after command beat");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled frame beat changed");

endmodule

bind mit_command_frame_encoder mcfe_check u_mcfe_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
